@@ hdl/tlbl_pkg.sv @@
// shared types, constants and codes for the translation buffer
`timescale 1ns / 1ps

package tlbl_pkg;

  // buffer geometry
  localparam int TLB_ENTRIES = 16;
  localparam int AGE_BITS    = 16;
  localparam int IDX_BITS    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CNT_BITS    = $clog2(TLB_ENTRIES + 1);

  // field widths
  localparam int OP_W    = 2;
  localparam int PAGE_W  = 32;
  localparam int FRAME_W = 20;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WB
  } state_t;

  // entry store access from the sequencer
  typedef struct packed {
    logic [IDX_BITS-1:0] rd_addr;
    logic                wr_entry;
    logic                wr_age;
    logic [IDX_BITS-1:0] wr_addr;
    logic [PAGE_W-1:0]   wr_page;
    logic [FRAME_W-1:0]  wr_frame;
    logic [AGE_BITS-1:0] wr_age_val;
  } mem_req_t;

  // registered read data from the entry store
  typedef struct packed {
    logic                valid;
    logic [PAGE_W-1:0]   page;
    logic [FRAME_W-1:0]  frame;
    logic [AGE_BITS-1:0] age;
  } mem_rsp_t;

endpackage

@@ hdl/tlbl_store.sv @@
// entry store: page, frame and age memories plus valid bits
`timescale 1ns / 1ps

module tlbl_store import tlbl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [PAGE_W-1:0]   page_mem  [TLB_ENTRIES];
  logic [FRAME_W-1:0]  frame_mem [TLB_ENTRIES];
  logic [AGE_BITS-1:0] age_mem   [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] entry_valid;
  logic [TLB_ENTRIES-1:0] age_ok;

  // valid bits; an age never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      age_ok      <= '0;
    end else begin
      if (req.wr_entry) entry_valid[req.wr_addr] <= 1'b1;
      if (req.wr_age)   age_ok[req.wr_addr]      <= 1'b1;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (req.wr_entry) begin
      page_mem[req.wr_addr]  <= req.wr_page;
      frame_mem[req.wr_addr] <= req.wr_frame;
    end
    if (req.wr_age) begin
      age_mem[req.wr_addr] <= req.wr_age_val;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rsp.valid <= entry_valid[req.rd_addr];
    rsp.page  <= page_mem[req.rd_addr];
    rsp.frame <= frame_mem[req.rd_addr];
    rsp.age   <= age_ok[req.rd_addr] ? age_mem[req.rd_addr] : '0;
  end

endmodule

@@ hdl/tlbl_alu.sv @@
// shared compare and age unit used once per visited entry
`timescale 1ns / 1ps

module tlbl_alu import tlbl_pkg::*; (
  input  logic [PAGE_W-1:0]   page_a,
  input  logic [PAGE_W-1:0]   page_b,
  input  logic [AGE_BITS-1:0] age_a,
  input  logic [AGE_BITS-1:0] age_b,
  output logic                match,
  output logic                older,
  output logic [AGE_BITS-1:0] age_inc
);

  // page match and strict age order
  assign match = (page_a == page_b);
  assign older = (age_a > age_b);

  // saturating increment
  assign age_inc = (age_a == '1) ? age_a : age_a + 1'b1;

endmodule

@@ hdl/tlbl_seq.sv @@
// sequencer: walks the entries one per cycle and does the write-back
`timescale 1ns / 1ps

module tlbl_seq import tlbl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [OP_W-1:0]    op,
  input  logic [PAGE_W-1:0]  vpn,
  input  logic [FRAME_W-1:0] pfn_in,
  output logic               busy,
  output logic               done,
  output logic               hit,
  output logic [FRAME_W-1:0] pfn_out,
  output mem_req_t           req,
  input  mem_rsp_t           rsp
);

  state_t state, state_next;
  logic [CNT_BITS-1:0] cnt;
  logic                rd_vld;
  logic [IDX_BITS-1:0] rd_idx;
  logic                issue;
  logic                last;
  logic                accept;

  logic [OP_W-1:0]     op_q;
  logic [PAGE_W-1:0]   vpn_q;
  logic [FRAME_W-1:0]  pfn_q;
  logic                found;
  logic [FRAME_W-1:0]  frame_q;
  logic                have_inv;
  logic [IDX_BITS-1:0] best_idx;
  logic [AGE_BITS-1:0] best_age;

  logic                match;
  logic                older;
  logic [AGE_BITS-1:0] age_inc;

  tlbl_alu u_alu (
    .page_a  (rsp.page),
    .page_b  (vpn_q),
    .age_a   (rsp.age),
    .age_b   (best_age),
    .match   (match),
    .older   (older),
    .age_inc (age_inc)
  );

  assign accept = start && (state == ST_IDLE);
  assign issue  = (state == ST_SCAN) && (cnt < CNT_BITS'(TLB_ENTRIES));
  assign last   = rd_vld && (rd_idx == IDX_BITS'(TLB_ENTRIES - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = (op == OP_NONE) ? ST_WB : ST_SCAN;
      end
      ST_SCAN: begin
        if (last) state_next = ST_WB;
      end
      ST_WB: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and store access
  always_comb begin
    busy           = (state != ST_IDLE);
    done           = 1'b0;
    req.rd_addr    = cnt[IDX_BITS-1:0];
    req.wr_entry   = 1'b0;
    req.wr_age     = 1'b0;
    req.wr_addr    = rd_idx;
    req.wr_page    = vpn_q;
    req.wr_frame   = pfn_q;
    req.wr_age_val = age_inc;
    case (state)
      ST_SCAN: begin
        // tick writes back each age right after reading it
        if (rd_vld && op_q == OP_TICK) req.wr_age = 1'b1;
      end
      ST_WB: begin
        done           = 1'b1;
        req.wr_addr    = best_idx;
        req.wr_age_val = '0;
        if (op_q == OP_INSERT) begin
          req.wr_entry = 1'b1;
          req.wr_age   = 1'b1;
        end else if (op_q == OP_LOOKUP && found) begin
          req.wr_age = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign hit     = found;
  assign pfn_out = frame_q;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (accept)     cnt <= '0;
      else if (issue) cnt <= cnt + 1'b1;
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    rd_idx <= cnt[IDX_BITS-1:0];
    if (accept) begin
      op_q     <= op;
      vpn_q    <= vpn;
      pfn_q    <= pfn_in;
      found    <= 1'b0;
      frame_q  <= '0;
      have_inv <= 1'b0;
      best_idx <= '0;
      best_age <= '0;
    end else if (state == ST_SCAN && rd_vld) begin
      case (op_q)
        OP_LOOKUP: begin
          // lowest-index valid match wins
          if (!found && rsp.valid && match) begin
            found    <= 1'b1;
            frame_q  <= rsp.frame;
            best_idx <= rd_idx;
          end
        end
        OP_INSERT: begin
          // first invalid entry, else oldest with lowest index on ties
          if (!have_inv) begin
            if (!rsp.valid) begin
              have_inv <= 1'b1;
              best_idx <= rd_idx;
            end else if (rd_idx == '0 || older) begin
              best_idx <= rd_idx;
              best_age <= rsp.age;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/tlb_lru_lookup_insert.sv @@
// top level of the fully associative translation buffer with lru ages
`timescale 1ns / 1ps
//
// Command channel: op, vpn and pfn_in are taken at a rising edge where start
// is high and busy is low. op 0 looks up vpn, op 1 inserts vpn -> pfn_in,
// op 2 ages every entry by one (saturating), op 3 does nothing.
// Result channel: done is high for exactly one cycle with hit and pfn_out;
// the receiver takes it in that cycle and cannot hold it off.
// Lookup, insert and tick each walk every entry before showing done; op 3
// skips the walk and shows done in the cycle after it is accepted.
// The sequencer reads one entry per cycle from a single registered memory
// port, so no new transaction is taken before the last one is done, and
// busy stays high until done has been shown.
// Reset (rst, synchronous) clears the sequencer, all valid bits and ages;
// no clearing pass is needed, the block is ready the cycle after reset.
// Page and frame of an entry are written only by insert.
//
module tlb_lru_lookup_insert import tlbl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    op,
  input  logic [PAGE_W-1:0]  vpn,
  input  logic [FRAME_W-1:0] pfn_in,
  output logic               done,
  output logic               hit,
  output logic [FRAME_W-1:0] pfn_out
);

  mem_req_t req;
  mem_rsp_t rsp;

  // entry walk and write-back control
  tlbl_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .op      (op),
    .vpn     (vpn),
    .pfn_in  (pfn_in),
    .busy    (busy),
    .done    (done),
    .hit     (hit),
    .pfn_out (pfn_out),
    .req     (req),
    .rsp     (rsp)
  );

  // entry storage
  tlbl_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

endmodule

@@ hdl/tlbl_chk.sv @@
// port-level checker for the translation buffer, bound to the top level
`timescale 1ns / 1ps

module tlbl_chk import tlbl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [OP_W-1:0]    op,
  input logic               done,
  input logic               hit,
  input logic [FRAME_W-1:0] pfn_out
);

  // a scanning transaction finishes after a fixed walk of all entries
  a_scan_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && op != OP_NONE |-> ##(TLB_ENTRIES + 2) done)
    else $error("scan transaction did not finish on time");

  // the unused op answers on the next cycle
  a_none_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && op == OP_NONE |=> done && !hit)
    else $error("unused op did not answer at once");

  // a miss carries frame zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> pfn_out == '0)
    else $error("miss with nonzero frame");

  // the result ends the transaction
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 !busy && !done)
    else $error("busy not released after result");

endmodule

bind tlb_lru_lookup_insert tlbl_chk u_tlbl_chk (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .op      (op),
  .done    (done),
  .hit     (hit),
  .pfn_out (pfn_out)
);

@@ dv/tb_top.sv @@
// self-checking testbench for the lru translation buffer: directed and random traffic
`timescale 1ns / 1ps

module tb_top;
  import tlbl_pkg::*;

  // one command transaction as offered to the block
  typedef struct {
    logic [OP_W-1:0]    op;
    logic [PAGE_W-1:0]  vpn;
    logic [FRAME_W-1:0] pfn;
  } cmd_t;

  // one translation result as the block should return it
  typedef struct {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } xlate_t;

  localparam logic [AGE_BITS-1:0] AGE_TOP = {AGE_BITS{1'b1}};
  localparam int POOL_SIZE = 32;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [OP_W-1:0]    op = OP_LOOKUP;
  logic [PAGE_W-1:0]  vpn = '0;
  logic [FRAME_W-1:0] pfn_in = '0;
  logic               busy;
  logic               done;
  logic               hit;
  logic [FRAME_W-1:0] pfn_out;

  // commands waiting for the driver, translations waiting for the block
  cmd_t   cmd_q[$];
  xlate_t xlate_q[$];

  // shadow copy of the buffer contents
  logic                tlb_valid [TLB_ENTRIES];
  logic [PAGE_W-1:0]   tlb_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0]  tlb_frame [TLB_ENTRIES];
  logic [AGE_BITS-1:0] tlb_age   [TLB_ENTRIES];

  logic [PAGE_W-1:0] page_pool [POOL_SIZE];

  int gap_pct    = 0;
  int sent_cnt   = 0;
  int acc_cnt    = 0;
  int result_cnt = 0;
  int hit_cnt    = 0;
  int evict_cnt  = 0;
  int err_cnt    = 0;

  tlb_lru_lookup_insert DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .op      (op),
    .vpn     (vpn),
    .pfn_in  (pfn_in),
    .done    (done),
    .hit     (hit),
    .pfn_out (pfn_out)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // apply one command to the shadow buffer and queue the translation it yields
  task automatic apply_tlb_op(input logic [OP_W-1:0] o, input logic [PAGE_W-1:0] p,
                              input logic [FRAME_W-1:0] f);
    xlate_t r;
    int     slot;
    r.hit   = 1'b0;
    r.frame = '0;
    slot    = -1;
    case (o)
      OP_LOOKUP: begin
        // lowest matching valid entry wins, only its age is cleared
        for (int i = 0; i < TLB_ENTRIES; i++)
          if (slot < 0 && tlb_valid[i] && tlb_page[i] == p) slot = i;
        if (slot >= 0) begin
          r.hit   = 1'b1;
          r.frame = tlb_frame[slot];
          tlb_age[slot] = '0;
        end
      end
      OP_INSERT: begin
        // free entry first, else the oldest with lowest index on ties
        for (int i = 0; i < TLB_ENTRIES; i++)
          if (slot < 0 && !tlb_valid[i]) slot = i;
        if (slot < 0) begin
          slot = 0;
          for (int i = 1; i < TLB_ENTRIES; i++)
            if (tlb_age[i] > tlb_age[slot]) slot = i;
          evict_cnt++;
        end
        tlb_valid[slot] = 1'b1;
        tlb_page[slot]  = p;
        tlb_frame[slot] = f;
        tlb_age[slot]   = '0;
      end
      OP_TICK: begin
        // saturating age increment on every entry
        for (int i = 0; i < TLB_ENTRIES; i++)
          if (tlb_age[i] != AGE_TOP) tlb_age[i] = tlb_age[i] + 1'b1;
      end
      default: ;
    endcase
    xlate_q.push_back(r);
  endtask

  task automatic queue_cmd(input logic [OP_W-1:0] o, input logic [PAGE_W-1:0] p,
                           input logic [FRAME_W-1:0] f);
    cmd_t c;
    c.op  = o;
    c.vpn = p;
    c.pfn = f;
    cmd_q.push_back(c);
  endtask

  // random mix: mostly pooled pages so lookups hit and inserts duplicate and evict
  task automatic queue_random(input int n);
    int                roll;
    logic [PAGE_W-1:0] p;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      p = ($urandom_range(9) < 7) ? page_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      if (roll < 45)
        queue_cmd(OP_LOOKUP, p, FRAME_W'($urandom));
      else if (roll < 75)
        queue_cmd(OP_INSERT, p, FRAME_W'($urandom));
      else if (roll < 97)
        queue_cmd(OP_TICK, $urandom, FRAME_W'($urandom));
      else
        queue_cmd(OP_NONE, p, FRAME_W'($urandom));
    end
  endtask

  // wait until every queued transaction has been accepted and answered
  task automatic drain;
    while (cmd_q.size() != 0 || sent_cnt != acc_cnt || xlate_q.size() != 0)
      @(negedge clk);
  endtask

  // driver: hold start until accepted, then offer the next command or idle
  always @(negedge clk) begin
    cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (start && sent_cnt != acc_cnt) begin
      start <= 1'b1;
    end else if (cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
      nxt = cmd_q.pop_front();
      start  <= 1'b1;
      op     <= nxt.op;
      vpn    <= nxt.vpn;
      pfn_in <= nxt.pfn;
      sent_cnt++;
    end else begin
      start  <= 1'b0;
      op     <= OP_W'($urandom);
      vpn    <= $urandom;
      pfn_in <= FRAME_W'($urandom);
    end
  end

  // monitor: check results against the oldest pending translation, predict on accept
  always @(posedge clk) begin
    xlate_t want;
    if (!rst) begin
      if (done) begin
        if (xlate_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result hit %0b pfn_out %05h", hit, pfn_out));
        end else begin
          want = xlate_q.pop_front();
          if (hit !== want.hit)
            report_mismatch($sformatf("result %0d hit %0b, want %0b",
                                      result_cnt, hit, want.hit));
          if (pfn_out !== want.frame)
            report_mismatch($sformatf("result %0d pfn_out %05h, want %05h",
                                      result_cnt, pfn_out, want.frame));
          result_cnt++;
          if (want.hit) hit_cnt++;
        end
      end
      if (start && !busy) begin
        apply_tlb_op(op, vpn, pfn_in);
        acc_cnt++;
      end
    end
  end

  // stimulus and end of run
  initial begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tlb_valid[i] = 1'b0;
      tlb_page[i]  = '0;
      tlb_frame[i] = '0;
      tlb_age[i]   = '0;
    end
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty buffer, field extremes, unused op, duplicates
    gap_pct = 0;
    queue_cmd(OP_LOOKUP, '0, '0);
    queue_cmd(OP_LOOKUP, '1, '1);
    queue_cmd(OP_NONE, '1, '1);
    queue_cmd(OP_TICK, '1, '1);
    queue_cmd(OP_INSERT, '0, '0);
    queue_cmd(OP_INSERT, '1, '1);
    queue_cmd(OP_LOOKUP, '0, '1);
    queue_cmd(OP_LOOKUP, '1, '0);
    queue_cmd(OP_INSERT, '1, 20'h5a5a5);
    queue_cmd(OP_LOOKUP, '1, '0);
    queue_cmd(OP_NONE, '0, '0);
    queue_cmd(OP_LOOKUP, 32'h0000_0001, '0);
    queue_cmd(OP_LOOKUP, 32'h8000_0000, '0);
    queue_cmd(OP_TICK, '0, '0);
    queue_cmd(OP_TICK, '0, '0);
    // fill the buffer, then age one entry less and evict
    for (int i = 3; i < TLB_ENTRIES; i++)
      queue_cmd(OP_INSERT, 32'h0000_0100 + i, 20'h00100 + FRAME_W'(i));
    queue_cmd(OP_TICK, '0, '0);
    queue_cmd(OP_LOOKUP, 32'h0000_0105, '0);
    queue_cmd(OP_INSERT, 32'hdead_0000, 20'habcde);
    queue_cmd(OP_LOOKUP, '0, '0);
    queue_cmd(OP_LOOKUP, 32'hdead_0000, '0);
    drain();

    // refresh one entry, age the rest once more, evict twice
    queue_cmd(OP_LOOKUP, 32'h0000_0107, '0);
    queue_cmd(OP_TICK, '0, '0);
    queue_cmd(OP_INSERT, 32'hbeef_0001, 20'h13579);
    queue_cmd(OP_INSERT, 32'hbeef_0002, 20'h2468a);
    queue_cmd(OP_LOOKUP, 32'h0000_0107, '0);
    queue_cmd(OP_LOOKUP, 32'hbeef_0001, '0);
    queue_cmd(OP_LOOKUP, 32'hbeef_0002, '0);
    queue_cmd(OP_LOOKUP, '1, '0);
    drain();

    // random traffic under several sender idle rates
    gap_pct = 0;
    queue_random(140);
    drain();
    gap_pct = 61;
    queue_random(140);
    drain();
    gap_pct = 0;
    queue_random(140);
    drain();
    gap_pct = 34;
    queue_random(140);
    drain();

    // let any stray result show up
    repeat (TLB_ENTRIES + 6) @(posedge clk);

    $display("checked %0d results: %0d lookup hits, %0d evictions",
             result_cnt, hit_cnt, evict_cnt);
    $display("sender idle rates 0, 61 and 34 percent of cycles");
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #1_000_000;
    $display("timeout waiting for results");
    $display("Mismatches found");
    $finish;
  end

endmodule
